// ----- rtl/spf_pkg.sv -----
// shared types and constants of the servo packet framer
`default_nettype none
package spf_pkg;

  localparam int unsigned MaxData    = 4;
  localparam int unsigned DataFields = 4;
  localparam int unsigned DataCap    = (MaxData < DataFields) ? MaxData : DataFields;
  localparam int unsigned IdxW       = (DataFields > 1) ? $clog2(DataFields) : 1;
  localparam int unsigned PosW       = 4;

  localparam logic [7:0]      SyncByte  = 8'hff;
  localparam logic [7:0]      LenBias   = 8'd3;
  localparam logic [PosW-1:0] HdrBytes  = PosW'(6);
  localparam logic [2:0]      ReplyLast = 3'd4;
  localparam logic [2:0]      CapCount  = 3'(DataCap);
  localparam logic [7:0]      IdReset   = 8'd1;

  typedef enum logic [1:0] {
    KindTx  = 2'd0,
    KindOk  = 2'd1,
    KindBad = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    RxSync0 = 3'd0,
    RxSync1 = 3'd1,
    RxId    = 3'd2,
    RxLen   = 3'd3
  } rx_pos_e;

  typedef struct packed {
    logic                       is_reply;
    logic                       hdr_ok;
    logic [7:0]                 rlen;
    logic [7:0]                 id;
    logic [7:0]                 len;
    logic [7:0]                 instr;
    logic [7:0]                 addr;
    logic [DataFields-1:0][7:0] data;
    logic [2:0]                 count;
    logic [7:0]                 csum;
  } job_t;

endpackage
`default_nettype wire

// ----- rtl/servo_packet_framer.sv -----
// top level of the servo packet framer
// A send item (op 0) becomes one instruction frame, FF FF id length instruction
// address data checksum, delivered one byte per output item (seven to eleven
// bytes), one per cycle from the back-end byte walker unless output stalls.
// Reply byte items (op 1) wait for queue room; every fifth reply byte yields
// one header verdict item. A two-entry job queue lets new items enter while a
// frame is still being sent. servo_id is written on the cfg channel, which is
// always ready, and must only be written while the block is idle.
`default_nettype none
module servo_packet_framer import spf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       op_i,
  input  wire logic [7:0] instruction_i,
  input  wire logic [7:0] address_i,
  input  wire logic [2:0] data_count_i,
  input  wire logic [7:0] data_byte0_i,
  input  wire logic [7:0] data_byte1_i,
  input  wire logic [7:0] data_byte2_i,
  input  wire logic [7:0] data_byte3_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      byte_value_o,
  output logic [7:0]      reply_length_o,
  output logic            last_o
);

  logic push, q_ready, q_valid, pop;
  job_t job_in, job_out;

  spf_front u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .op_i, .instruction_i, .address_i, .data_count_i,
    .data_byte0_i, .data_byte1_i, .data_byte2_i, .data_byte3_i,
    .rx_byte_i,
    .push_o    (push),
    .job_o     (job_in),
    .q_ready_i (q_ready)
  );

  spf_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .job_i   (job_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .job_o   (job_out),
    .pop_i   (pop)
  );

  spf_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .job_i     (job_out),
    .pop_o     (pop),
    .out_valid_o, .out_ready_i,
    .kind_o, .byte_value_o, .reply_length_o, .last_o
  );

endmodule
`default_nettype wire

// ----- rtl/spf_front.sv -----
// front end: takes items, tracks reply headers, builds frame jobs
`default_nettype none
module spf_front import spf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       op_i,
  input  wire logic [7:0] instruction_i,
  input  wire logic [7:0] address_i,
  input  wire logic [2:0] data_count_i,
  input  wire logic [7:0] data_byte0_i,
  input  wire logic [7:0] data_byte1_i,
  input  wire logic [7:0] data_byte2_i,
  input  wire logic [7:0] data_byte3_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            push_o,
  output job_t            job_o,
  input  wire logic       q_ready_i
);

  logic [7:0] servo_id_q;
  logic [2:0] rx_pos_q, rx_pos_d;
  logic       rx_ok_q, rx_ok_d;
  logic [7:0] rx_len_q, rx_len_d;
  logic       accept;
  logic [2:0] cnt;
  logic [7:0] sum;
  logic [3:0][7:0] din;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = q_ready_i;
  assign accept      = in_valid_i && q_ready_i;
  assign din         = {data_byte3_i, data_byte2_i, data_byte1_i, data_byte0_i};
  assign cnt         = (data_count_i > CapCount) ? CapCount : data_count_i;

  always_comb begin
    sum = servo_id_q + (8'(cnt) + LenBias) + instruction_i + address_i;
    for (int i = 0; i < DataFields; i++) begin
      if (3'(i) < cnt) sum = sum + din[i];
    end
  end

  always_comb begin
    job_o.is_reply = op_i;
    job_o.hdr_ok   = rx_ok_q;
    job_o.rlen     = rx_ok_q ? rx_len_q : 8'd0;
    job_o.id       = servo_id_q;
    job_o.len      = 8'(cnt) + LenBias;
    job_o.instr    = instruction_i;
    job_o.addr     = address_i;
    for (int i = 0; i < DataFields; i++) job_o.data[i] = din[i];
    job_o.count    = cnt;
    job_o.csum     = ~sum;
  end

  assign push_o = accept && (!op_i || rx_pos_q == ReplyLast);

  always_comb begin
    rx_pos_d = rx_pos_q;
    rx_ok_d  = rx_ok_q;
    rx_len_d = rx_len_q;
    if (accept) begin
      if (!op_i || rx_pos_q == ReplyLast) begin
        rx_pos_d = 3'd0;
        rx_ok_d  = 1'b1;
        rx_len_d = 8'd0;
      end else begin
        rx_pos_d = rx_pos_q + 3'd1;
        case (rx_pos_q)
          RxSync0, RxSync1: if (rx_byte_i != SyncByte) rx_ok_d = 1'b0;
          RxId:             if (rx_byte_i != servo_id_q) rx_ok_d = 1'b0;
          RxLen:            rx_len_d = rx_byte_i;
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_id_q <= IdReset;
      rx_pos_q   <= 3'd0;
      rx_ok_q    <= 1'b1;
      rx_len_q   <= 8'd0;
    end else begin
      if (cfg_valid_i) servo_id_q <= cfg_data_i;
      rx_pos_q <= rx_pos_d;
      rx_ok_q  <= rx_ok_d;
      rx_len_q <= rx_len_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spf_queue.sv -----
// two-entry job queue between front and back
`default_nettype none
module spf_queue import spf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  output logic      ready_o,
  output logic      valid_o,
  output job_t      job_o,
  input  wire logic pop_i
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spf_back.sv -----
// back end: walks a job byte by byte into the output register
`default_nettype none
module spf_back import spf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  job_t            job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      byte_value_o,
  output logic [7:0]      reply_length_o,
  output logic            last_o
);

  logic [PosW-1:0] pos_q;
  logic            valid_q;
  kind_e           kind_q;
  logic [7:0]      byte_q, rlen_q;
  logic            last_q;
  logic            adv, fin;
  logic [PosW-1:0] end_pos, didx;
  logic [7:0]      sel;

  assign adv     = q_valid_i && (!valid_q || out_ready_i);
  assign end_pos = HdrBytes + PosW'(job_i.count);
  assign didx    = pos_q - HdrBytes;
  assign fin     = job_i.is_reply || pos_q == end_pos;
  assign pop_o   = adv && fin;

  always_comb begin
    case (pos_q)
      4'd0, 4'd1: sel = SyncByte;
      4'd2:       sel = job_i.id;
      4'd3:       sel = job_i.len;
      4'd4:       sel = job_i.instr;
      4'd5:       sel = job_i.addr;
      default:    sel = (pos_q == end_pos) ? job_i.csum : job_i.data[didx[IdxW-1:0]];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q <= job_i.is_reply ? (job_i.hdr_ok ? KindOk : KindBad) : KindTx;
      byte_q <= job_i.is_reply ? 8'd0 : sel;
      rlen_q <= job_i.is_reply ? job_i.rlen : 8'd0;
      last_q <= fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      if (adv) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
      if (adv) pos_q <= fin ? '0 : pos_q + PosW'(1);
    end
  end

  assign out_valid_o    = valid_q;
  assign kind_o         = kind_q;
  assign byte_value_o   = byte_q;
  assign reply_length_o = rlen_q;
  assign last_o         = last_q;

endmodule
`default_nettype wire
